// ===== hw/rtl/afcc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, fault table and constants for the active fault code cycler.
// No dependencies.
package afcc_pkg;

  localparam int SLOT_COUNT    = 16;
  localparam int TABLE_ENTRIES = 11;
  localparam int FAULT_SLOTS   = 11;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] NO_FAULT_VALUE = 8'd0;

  localparam logic [2:0] SRC_CPR      = 3'd0;
  localparam logic [2:0] SRC_POWER    = 3'd1;
  localparam logic [2:0] SRC_AUDIO    = 3'd2;
  localparam logic [2:0] SRC_WIRELESS = 3'd3;
  localparam logic [2:0] SRC_STORAGE  = 3'd4;

  localparam logic [7:0] ENTRY_CODE [SLOT_COUNT] = '{
    8'd1, 8'd2, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd21, 8'd22, 8'd31, 8'd41,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };
  localparam logic [2:0] ENTRY_SOURCE [SLOT_COUNT] = '{
    SRC_CPR, SRC_CPR, SRC_POWER, SRC_POWER, SRC_POWER, SRC_POWER, SRC_POWER,
    SRC_AUDIO, SRC_AUDIO, SRC_WIRELESS, SRC_STORAGE,
    SRC_CPR, SRC_CPR, SRC_CPR, SRC_CPR, SRC_CPR
  };
  localparam logic [7:0] ENTRY_MASK [SLOT_COUNT] = '{
    8'h02, 8'h04, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h02, 8'h04, 8'h02, 8'h02,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [7:0] cpr_status;
    logic [7:0] power_status;
    logic [7:0] audio_status;
    logic [7:0] wireless_status;
    logic [7:0] storage_status;
  } afcc_in_t;

  typedef struct packed {
    logic [7:0] shown_code;
    logic [3:0] active_count;
    logic [3:0] shown_index;
  } afcc_out_t;

  // Compacted active codes of one transaction, handed from front to back.
  typedef struct packed {
    logic [3:0]                  count;
    logic [FAULT_SLOTS-1:0][7:0] codes;
  } afcc_work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } afcc_qstat_t;

endpackage

// ===== hw/rtl/afcc_front.sv =====
`timescale 1ns / 1ps
// Front end: maps status bits through the fault table and compacts the active codes.
// Depends on afcc_pkg.
module afcc_front import afcc_pkg::*; (
  input  afcc_in_t   in_data,
  output afcc_work_t work
);

  logic [SLOT_COUNT-1:0] hit;
  logic [4:0]            pos [SLOT_COUNT];
  logic [4:0]            total;
  logic [7:0]            src_byte;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      case (ENTRY_SOURCE[i])
        SRC_CPR:      src_byte = in_data.cpr_status;
        SRC_POWER:    src_byte = in_data.power_status;
        SRC_AUDIO:    src_byte = in_data.audio_status;
        SRC_WIRELESS: src_byte = in_data.wireless_status;
        SRC_STORAGE:  src_byte = in_data.storage_status;
        default:      src_byte = 8'd0;
      endcase
      hit[i] = (i < TABLE_ENTRIES) && ((src_byte & ENTRY_MASK[i]) != 8'd0);
    end
  end

  // Each entry's slot is the number of active entries below it.
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      pos[i] = 5'd0;
      for (int k = 0; k < i; k++) begin
        pos[i] = pos[i] + 5'(hit[k]);
      end
    end
    total = pos[SLOT_COUNT-1] + 5'(hit[SLOT_COUNT-1]);
  end

  always_comb begin
    work.count = total[3:0];
    for (int j = 0; j < FAULT_SLOTS; j++) begin
      work.codes[j] = 8'd0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (hit[i] && (pos[i] == 5'(j))) begin
          work.codes[j] = work.codes[j] | ENTRY_CODE[i];
        end
      end
    end
  end

endmodule

// ===== hw/rtl/afcc_queue.sv =====
`timescale 1ns / 1ps
// Short queue of compacted transactions between front and back.
// Depends on afcc_pkg.
module afcc_queue import afcc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  afcc_work_t  wr_data,
  input  logic        pop,
  output afcc_work_t  rd_data,
  output afcc_qstat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  afcc_work_t          entry_r [DEPTH];
  logic [PW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  logic                do_push, do_pop;

  assign stat.full  = (fill_r == FW'(DEPTH));
  assign stat.empty = (fill_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    fill_nxt = fill_r + FW'(do_push) - FW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DEPTH))
    else $error("queue fill exceeds depth");
  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !stat.empty)
    else $error("queue full and empty at once");
  a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !do_push && !do_pop |=> $stable(fill_r))
    else $error("queue fill moved without a transaction");
`endif

endmodule

// ===== hw/rtl/afcc_back.sv =====
`timescale 1ns / 1ps
// Back end: rotation state, code selection and the result register.
// Depends on afcc_pkg.
module afcc_back import afcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  afcc_work_t  work,
  input  logic        work_avail,
  output logic        work_take,
  input  logic        out_pop,
  output logic        out_empty,
  output afcc_out_t   out_data
);

  logic [3:0] prev_cnt_r, prev_cnt_nxt;
  logic [3:0] rot_idx_r, rot_idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  afcc_out_t  out_data_r, out_data_nxt;
  logic [4:0] step;

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;
  assign work_take = work_avail && (!out_valid_r || out_pop);

  always_comb begin
    prev_cnt_nxt  = prev_cnt_r;
    rot_idx_nxt   = rot_idx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_pop;
    step          = {1'b0, rot_idx_r} + 5'd1;
    if (work_take) begin
      if (work.count == 4'd0) begin
        rot_idx_nxt = 4'd0;
      end else if (work.count != prev_cnt_r) begin
        rot_idx_nxt  = 4'd0;
        prev_cnt_nxt = work.count;
      end else begin
        rot_idx_nxt = (step >= {1'b0, work.count}) ? 4'd0 : step[3:0];
      end
      out_data_nxt.active_count = work.count;
      out_data_nxt.shown_index  = rot_idx_nxt;
      out_data_nxt.shown_code   = (work.count == 4'd0) ? NO_FAULT_VALUE
                                                       : work.codes[rot_idx_nxt];
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cnt_r  <= 4'd0;
      rot_idx_r   <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      prev_cnt_r  <= prev_cnt_nxt;
      rot_idx_r   <= rot_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    work_take && (work.count != 4'd0) |=> out_data_r.shown_index < out_data_r.active_count)
    else $error("shown index not below active count");
  a_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    work_take && (work.count == 4'd0) |=>
      (out_data_r.shown_code == NO_FAULT_VALUE) && (out_data_r.shown_index == 4'd0)
      && (rot_idx_r == 4'd0))
    else $error("no-fault transaction shown wrong");
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    work_take && (work.count != 4'd0) && (work.count != prev_cnt_r) |=>
      (rot_idx_r == 4'd0) && (prev_cnt_r == $past(work.count)))
    else $error("count change did not restart rotation");
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pop |-> !work_take)
    else $error("result overwritten before pop");
`endif

endmodule

// ===== hw/rtl/active_fault_code_cycler_top.sv =====
`timescale 1ns / 1ps
// Top level of the active fault code cycler: front, queue and back joined.
// Depends on afcc_pkg, afcc_front, afcc_queue, afcc_back.
// One transaction carries the five module status bytes of a display tick and yields one
// result: the fault code to show, the number of active faults and the index of the shown
// code. The block sustains one transaction per clock while results are popped as they
// appear; the queue entry is written when a transaction is accepted and the result
// register loads when the back end takes it. Up to three transactions are held inside,
// two in the queue and one in the result register; full rises once the queue holds two,
// so up to two transactions can still enter while a single result waits to be popped.
module active_fault_code_cycler_top import afcc_pkg::*; #(
  parameter int QUEUE_ENTRIES = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  afcc_in_t  in_data,
  input  logic      out_pop,
  output logic      out_empty,
  output afcc_out_t out_data
);

  afcc_work_t  front_work;
  afcc_work_t  queue_work;
  afcc_qstat_t qstat;
  logic        back_take;

  assign in_full = qstat.full;

  afcc_front u_front (
    .in_data (in_data),
    .work    (front_work)
  );

  afcc_queue #(
    .DEPTH (QUEUE_ENTRIES)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (front_work),
    .pop     (back_take),
    .rd_data (queue_work),
    .stat    (qstat)
  );

  afcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .work       (queue_work),
    .work_avail (!qstat.empty),
    .work_take  (back_take),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_data   (out_data)
  );

endmodule

// ===== sim/active_fault_code_cycler_checker.sv =====
`timescale 1ns / 1ps
// Result checker for active_fault_code_cycler_top: predicts each display result
// from the accepted status transactions and compares it with the popped one.
// Depends on afcc_pkg for the payload types and the no-fault code.
module active_fault_code_cycler_checker import afcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  logic      in_full,
  input  afcc_in_t  in_data,
  input  logic      out_pop,
  input  logic      out_empty,
  input  afcc_out_t out_data,
  output int        mismatches,
  output int        pending,
  output int        checked,
  output int        no_fault_ticks,
  output int        wraps
);

  localparam int FAULT_BITS = 11;
  localparam int MAX_REPORTS = 10;

  localparam logic [7:0] BIT_CODE [FAULT_BITS] = '{
    8'd1, 8'd2, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd21, 8'd22, 8'd31, 8'd41
  };
  localparam logic [2:0] FAULT_BYTE [FAULT_BITS] = '{
    SRC_CPR, SRC_CPR, SRC_POWER, SRC_POWER, SRC_POWER, SRC_POWER, SRC_POWER,
    SRC_AUDIO, SRC_AUDIO, SRC_WIRELESS, SRC_STORAGE
  };
  localparam logic [7:0] FAULT_MASK [FAULT_BITS] = '{
    8'h02, 8'h04, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h02, 8'h04, 8'h02, 8'h02
  };

  logic [3:0] seen_count = '0;
  logic [3:0] cursor = '0;
  afcc_out_t  expected_displays [$];

  int n_mismatch = 0;
  int n_checked = 0;
  int n_no_fault = 0;
  int n_wraps = 0;

  initial begin
    mismatches = 0;
    pending = 0;
    checked = 0;
    no_fault_ticks = 0;
    wraps = 0;
  end

  // Compacts the active codes, then moves the rotation cursor.
  function automatic afcc_out_t predict_display(afcc_in_t tick);
    logic [7:0] status [5];
    logic [7:0] codes [FAULT_BITS];
    logic [3:0] n;
    logic [4:0] next;
    afcc_out_t  r;
    int         i;
    status[SRC_CPR]      = tick.cpr_status;
    status[SRC_POWER]    = tick.power_status;
    status[SRC_AUDIO]    = tick.audio_status;
    status[SRC_WIRELESS] = tick.wireless_status;
    status[SRC_STORAGE]  = tick.storage_status;
    n = '0;
    for (i = 0; i < FAULT_BITS; i++) begin
      codes[i] = '0;
      if ((status[FAULT_BYTE[i]] & FAULT_MASK[i]) != 8'h00) begin
        codes[n] = BIT_CODE[i];
        n++;
      end
    end
    if (n == 4'd0) begin
      // seen_count is kept across a no-fault tick
      cursor = '0;
      r.shown_code = NO_FAULT_VALUE;
    end else begin
      if (n != seen_count) begin
        cursor = '0;
        seen_count = n;
      end else begin
        next = {1'b0, cursor} + 5'd1;
        cursor = (next >= {1'b0, n}) ? 4'd0 : next[3:0];
      end
      r.shown_code = codes[cursor];
    end
    r.active_count = n;
    r.shown_index = cursor;
    return r;
  endfunction

  always @(posedge clk) begin
    afcc_out_t  want;
    logic [3:0] prior;
    if (!rst_n) begin
      seen_count = '0;
      cursor = '0;
      expected_displays.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_displays.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display("unexpected display result: code %0d count %0d index %0d",
                     out_data.shown_code, out_data.active_count, out_data.shown_index);
        end else begin
          want = expected_displays.pop_front();
          n_checked++;
          if (out_data.shown_code !== want.shown_code ||
              out_data.active_count !== want.active_count ||
              out_data.shown_index !== want.shown_index) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
              $display("display %0d mismatch: expected code %0d count %0d index %0d, %s",
                       n_checked, want.shown_code, want.active_count, want.shown_index,
                       $sformatf("got code %0d count %0d index %0d", out_data.shown_code,
                                 out_data.active_count, out_data.shown_index));
          end
        end
      end
      if (in_push && !in_full) begin
        prior = seen_count;
        want = predict_display(in_data);
        if (want.active_count == 4'd0)
          n_no_fault++;
        else if (want.active_count == prior && want.shown_index == 4'd0)
          n_wraps++;
        expected_displays.push_back(want);
      end
    end
    mismatches <= n_mismatch;
    pending <= expected_displays.size();
    checked <= n_checked;
    no_fault_ticks <= n_no_fault;
    wraps <= n_wraps;
  end

endmodule

// ===== sim/active_fault_code_cycler_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for active_fault_code_cycler_top: directed and random status
// ticks with bursty input, patterned result pops and a long receiver hold-off.
// Depends on afcc_pkg, active_fault_code_cycler_top, active_fault_code_cycler_checker.
module active_fault_code_cycler_top_tb;
  import afcc_pkg::*;

  localparam int RANDOM_TICKS   = 1900;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;

  // status bits that map to a fault code
  localparam logic [7:0] CPR_USED      = 8'h06;
  localparam logic [7:0] POWER_USED    = 8'h3E;
  localparam logic [7:0] AUDIO_USED    = 8'h06;
  localparam logic [7:0] WIRELESS_USED = 8'h02;
  localparam logic [7:0] STORAGE_USED  = 8'h02;

  typedef enum int {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_CADENCE} pop_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  afcc_in_t  in_data = '0;
  logic      in_full;
  logic      out_pop = 1'b0;
  logic      out_empty;
  afcc_out_t out_data;

  int mismatches, pending, checked, no_fault_ticks, wraps;
  int sent = 0;
  int directed = 0;
  int long_holds = 0;
  int stall_cycles = 0;

  afcc_in_t tick_plan [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  active_fault_code_cycler_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

  active_fault_code_cycler_checker display_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_data        (in_data),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_data       (out_data),
    .mismatches     (mismatches),
    .pending        (pending),
    .checked        (checked),
    .no_fault_ticks (no_fault_ticks),
    .wraps          (wraps)
  );

  function automatic afcc_in_t status_tick(logic [7:0] c, logic [7:0] p, logic [7:0] a,
                                           logic [7:0] w, logic [7:0] s);
    afcc_in_t t;
    t.cpr_status = c;
    t.power_status = p;
    t.audio_status = a;
    t.wireless_status = w;
    t.storage_status = s;
    return t;
  endfunction

  function automatic logic [7:0] random_status_byte();
    case ($urandom_range(0, 5))
      0, 1: return 8'h00;
      2: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Changes only bits without a table entry, so the active set stays the same.
  function automatic afcc_in_t stir_unused_bits(afcc_in_t t);
    t.cpr_status      ^= 8'($urandom) & ~CPR_USED;
    t.power_status    ^= 8'($urandom) & ~POWER_USED;
    t.audio_status    ^= 8'($urandom) & ~AUDIO_USED;
    t.wireless_status ^= 8'($urandom) & ~WIRELESS_USED;
    t.storage_status  ^= 8'($urandom) & ~STORAGE_USED;
    return t;
  endfunction

  task automatic build_plan();
    afcc_in_t base;
    afcc_in_t t;
    int run_len;
    int k;
    tick_plan.push_back(status_tick(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // full table, long enough to wrap the rotation
    repeat (12) tick_plan.push_back(status_tick(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    tick_plan.push_back(status_tick(~CPR_USED, ~POWER_USED, ~AUDIO_USED, ~WIRELESS_USED,
                                    ~STORAGE_USED));
    // same count returns after a no-fault tick
    tick_plan.push_back(status_tick(CPR_USED, 8'h00, 8'h00, 8'h00, 8'h00));
    tick_plan.push_back(status_tick(CPR_USED, 8'h00, 8'h00, 8'h00, 8'h00));
    tick_plan.push_back(status_tick(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    tick_plan.push_back(status_tick(CPR_USED, 8'h00, 8'h00, 8'h00, 8'h00));
    tick_plan.push_back(status_tick(8'h00, POWER_USED, 8'h00, 8'h00, 8'h00));
    tick_plan.push_back(status_tick(8'h00, 8'h00, AUDIO_USED, WIRELESS_USED, STORAGE_USED));
    tick_plan.push_back(status_tick(8'h00, 8'h00, 8'h00, 8'h00, STORAGE_USED));
    directed = tick_plan.size();
    while (tick_plan.size() < directed + RANDOM_TICKS) begin
      if ($urandom_range(0, 9) < 8) begin
        // steady status with random content lets the index run and wrap
        base = status_tick(random_status_byte(), random_status_byte(), random_status_byte(),
                           random_status_byte(), random_status_byte());
        run_len = $urandom_range(2, 14);
        for (k = 0; k < run_len; k++) begin
          t = base;
          if ($urandom_range(0, 2) == 0)
            t = stir_unused_bits(t);
          if ($urandom_range(0, 19) == 0)
            t = '0;
          tick_plan.push_back(t);
        end
      end else begin
        tick_plan.push_back(status_tick(8'($urandom), 8'($urandom), 8'($urandom),
                                        8'($urandom), 8'($urandom)));
      end
    end
  endtask

  initial begin : sender
    int burst;
    int gap;
    build_plan();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (tick_plan.size() > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && tick_plan.size() > 0) begin
        in_push <= 1'b1;
        in_data <= tick_plan.pop_front();
        do @(posedge clk); while (in_full);
        sent++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Summary: %0d status ticks sent (%0d directed), %0d displays checked",
             sent, directed, checked);
    $display("Summary: %0d no-fault ticks, %0d rotation wraps, %0d long receiver holds",
             no_fault_ticks, wraps, long_holds);
    if (mismatches == 0 && pending == 0) begin
      $display("active_fault_code_cycler_top regression: pass");
    end else begin
      $display("active_fault_code_cycler_top regression: fail");
    end
    $finish;
  end

  initial begin : receiver
    pop_mode_t mode;
    int seg_len;
    int segment;
    int step;
    segment = 0;
    wait (rst_n === 1'b1);
    forever begin
      segment++;
      if (segment % 12 == 4) begin
        out_pop <= 1'b0;
        long_holds++;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = pop_mode_t'($urandom_range(0, 3));
        seg_len = $urandom_range(4, 60);
        for (step = 0; step < seg_len; step++) begin
          case (mode)
            POP_ALWAYS:  out_pop <= 1'b1;
            POP_COIN:    out_pop <= 1'($urandom_range(0, 1));
            POP_SPARSE:  out_pop <= ($urandom_range(0, 3) == 0);
            POP_CADENCE: out_pop <= (step % 3 != 0);
            default:     out_pop <= 1'b1;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results pending",
                 stall_cycles, pending);
        $display("active_fault_code_cycler_top regression: fail");
        $finish;
      end
    end
  end

endmodule

// ===== active_fault_code_cycler_top.f =====
hw/rtl/afcc_pkg.sv
hw/rtl/afcc_front.sv
hw/rtl/afcc_queue.sv
hw/rtl/afcc_back.sv
hw/rtl/active_fault_code_cycler_top.sv
sim/active_fault_code_cycler_checker.sv
sim/active_fault_code_cycler_top_tb.sv
